/* design/mrsm_pkg.sv */
// Package of the multi-ring saturating mixer: stream widths, codes, saturation limits,
// parameter defaults and the pointer-table command struct.
// No dependencies; every other file of the block but mrsm_ram imports it.
package mrsm_pkg;

  // Parameter defaults.
  localparam int DEF_RING_DEPTH   = 4096;
  localparam int DEF_NUM_SPEAKERS = 4;
  localparam int DEF_NUM_CHANNELS = 3;

  // Stream word widths.
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 1;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 13;

  // Saturation limits of the mixed sample.
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // Operation codes on the input stream.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result kinds on the output stream.
  localparam logic KIND_MIX    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Commands to the pointer table.
  typedef struct packed {
    logic pop;     // advance the read pointer of the looked-up ring
    logic commit;  // load the write pointer of the commit ring
  } ptr_cmd_t;

endpackage

/* design/mrsm_ram.sv */
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing; used for the sample storage of the mixer.
module mrsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mrsm_ptr_tbl.sv */
// Read and write pointers of every ring, with the fill level of the looked-up ring.
// Depends on mrsm_pkg for the command struct.
module mrsm_ptr_tbl #(
  parameter int RING_DEPTH = mrsm_pkg::DEF_RING_DEPTH,
  parameter int NUM_RINGS  = mrsm_pkg::DEF_NUM_SPEAKERS * mrsm_pkg::DEF_NUM_CHANNELS,
  parameter int RIDX_W     = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1,
  parameter int PW         = $clog2(2 * RING_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrsm_pkg::ptr_cmd_t cmd_i,
  input  logic [RIDX_W-1:0] idx_i,
  input  logic [RIDX_W-1:0] commit_idx_i,
  input  logic [PW-1:0]     commit_ptr_i,
  output logic [PW-1:0]     rd_ptr_o,
  output logic [PW-1:0]     wr_ptr_o,
  output logic [PW-1:0]     fill_o
);
  import mrsm_pkg::*;

  localparam int SPAN = 2 * RING_DEPTH;

  logic [PW-1:0] rp_q [NUM_RINGS];
  logic [PW-1:0] wp_q [NUM_RINGS];
  logic          idx_ok;
  logic [PW-1:0] rp_nx;
  logic [PW:0]   diff;

  assign idx_ok   = int'(idx_i) < NUM_RINGS;
  assign rd_ptr_o = idx_ok ? rp_q[idx_i] : '0;
  assign wr_ptr_o = idx_ok ? wp_q[idx_i] : '0;
  assign rp_nx    = (rd_ptr_o == PW'(SPAN - 1)) ? '0 : rd_ptr_o + 1'b1;

  // Fill level, both pointers counting modulo twice the ring depth.
  always_comb begin
    if (wr_ptr_o >= rd_ptr_o) begin
      diff = {1'b0, wr_ptr_o} - {1'b0, rd_ptr_o};
    end else begin
      diff = {1'b0, wr_ptr_o} + (PW+1)'(SPAN) - {1'b0, rd_ptr_o};
    end
  end
  assign fill_o = diff[PW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_RINGS; i++) begin
        rp_q[i] <= '0;
        wp_q[i] <= '0;
      end
    end else begin
      if (cmd_i.pop && idx_ok) begin
        rp_q[idx_i] <= rp_nx;
      end
      if (cmd_i.commit && (int'(commit_idx_i) < NUM_RINGS)) begin
        wp_q[commit_idx_i] <= commit_ptr_i;
      end
    end
  end

endmodule

/* design/mrsm_mix_acc.sv */
// Accumulator of popped samples with saturation of the sum to 16 bits.
// Depends on mrsm_pkg for sample width and saturation limits.
module mrsm_mix_acc #(
  parameter int NUM_SPEAKERS = mrsm_pkg::DEF_NUM_SPEAKERS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clr_i,
  input  logic                                add_i,
  input  logic signed [mrsm_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [mrsm_pkg::SAMPLE_W-1:0] sum_o
);
  import mrsm_pkg::*;

  localparam int ACC_W = SAMPLE_W + $clog2(NUM_SPEAKERS) + 1;

  logic signed [ACC_W-1:0] acc_q, acc_d;

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (add_i) begin
      acc_d = acc_q + ACC_W'(sample_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_comb begin
    if (acc_q > $signed(ACC_W'(SAT_MAX))) begin
      sum_o = SAMPLE_W'(SAT_MAX);
    end else if (acc_q < $signed(ACC_W'(SAT_MIN))) begin
      sum_o = SAMPLE_W'(SAT_MIN);
    end else begin
      sum_o = acc_q[SAMPLE_W-1:0];
    end
  end

endmodule

/* design/multi_ring_saturating_mixer_core.sv */
// Top level of the multi-ring saturating mixer: packet writes into per-ring FIFOs and
// mixed reads across the speakers of one channel. Uses mrsm_pkg, mrsm_ram,
// mrsm_ptr_tbl and mrsm_mix_acc.
//
//   channel   direction  words                             handshake
//   s_axis    in         write sample or read request      tvalid/tready, tlast, tuser
//   m_axis    out        mixed sample or packet status     tvalid/tready, tuser
//
// A write word passes through three states (accept, admission decision, store and commit).
// A read word issues one sample memory read per non-empty speaker ring, one per cycle,
// through the single memory port, then the last read data is added and the saturated sum
// is registered for output.
// Reset clears all ring pointers and the open-packet state at once; the sample memory
// needs no clearing since only committed entries are ever read.
// A finished result waits in the output register; the block stalls only when a second
// result is ready before the first one has been taken.
module multi_ring_saturating_mixer_core #(
  parameter int RING_DEPTH   = mrsm_pkg::DEF_RING_DEPTH,
  parameter int NUM_SPEAKERS = mrsm_pkg::DEF_NUM_SPEAKERS,
  parameter int NUM_CHANNELS = mrsm_pkg::DEF_NUM_CHANNELS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata from bit 0 up: speaker (2), channel (2), sample (16), packet_len (13), zero pad (7).
  input  logic [mrsm_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser from bit 0 up: op (1), first_of_packet (1).
  input  logic [mrsm_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  // tlast carries last_of_packet.
  input  logic                           s_axis_tlast_i,
  // Output stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata from bit 0 up: mixed_sample (16), packet_dropped (1), zero pad (7).
  output logic [mrsm_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser from bit 0 up: kind (1).
  output logic [mrsm_pkg::M_TUSER_W-1:0] m_axis_tuser_o
);
  import mrsm_pkg::*;

  localparam int NUM_RINGS = NUM_SPEAKERS * NUM_CHANNELS;
  localparam int RIDX_W    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int SCNT_W    = (NUM_SPEAKERS > 1) ? $clog2(NUM_SPEAKERS) : 1;
  localparam int PW        = $clog2(2 * RING_DEPTH);
  localparam int SLW       = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = NUM_RINGS * RING_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SPAN      = 2 * RING_DEPTH;
  localparam int CW        = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WDEC   = 6'b000010,
    ST_WSTORE = 6'b000100,
    ST_RISSUE = 6'b001000,
    ST_RDRAIN = 6'b010000,
    ST_ROUT   = 6'b100000
  } st_e;

  st_e state_q, state_d;

  // Captured input word.
  logic                       first_q, last_q;
  logic [1:0]                 spk_q, ch_q;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic [LEN_W-1:0]           len_q;

  // Open packet state.
  logic              pkt_acc_q, pkt_acc_d;
  logic [RIDX_W-1:0] pkt_ring_q, pkt_ring_d;
  logic [LEN_W-1:0]  pkt_left_q, pkt_left_d;
  logic [PW-1:0]     pend_q, pend_d;

  // Read sweep state.
  logic [SCNT_W-1:0] spk_cnt_q, spk_cnt_d;
  logic              rd_vld_q, rd_vld_d;

  // Output register.
  logic                       out_vld_q, out_vld_d;
  logic                       out_kind_q, out_kind_d;
  logic signed [SAMPLE_W-1:0] out_smp_q, out_smp_d;
  logic                       out_drop_q, out_drop_d;

  // Pointer table and memory connections.
  ptr_cmd_t          ptr_cmd;
  logic [RIDX_W-1:0] lk_idx;
  logic [PW-1:0]     lk_rd_ptr, lk_wr_ptr, lk_fill;
  logic [PW-1:0]     commit_ptr;

  logic                       mem_en, mem_we;
  logic [AW-1:0]              mem_addr;
  logic signed [SAMPLE_W-1:0] mem_rdata;

  logic                       acc_clr, acc_add;
  logic signed [SAMPLE_W-1:0] mix_sum;

  // Derived values.
  logic              s_fire, out_free;
  logic              wr_ring_ok, rd_ch_ok;
  logic [RIDX_W-1:0] wr_ring, rd_ring;
  logic [PW:0]       room;
  logic              fits;
  logic              do_store;
  logic [PW-1:0]     pend_nx;
  logic [SLW-1:0]    pend_slot, rd_slot;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  // Ring indices of the write target and of the speaker currently swept by a read.
  assign wr_ring_ok = (int'(spk_q) < NUM_SPEAKERS) && (int'(ch_q) < NUM_CHANNELS);
  assign rd_ch_ok   = int'(ch_q) < NUM_CHANNELS;
  assign wr_ring    = RIDX_W'(int'(spk_q) * NUM_CHANNELS + int'(ch_q));
  assign rd_ring    = RIDX_W'(int'(spk_cnt_q) * NUM_CHANNELS + int'(ch_q));
  assign lk_idx     = (state_q == ST_RISSUE) ? rd_ring : wr_ring;

  // Admission check: the whole packet must fit in the free space of the ring.
  assign room = (PW+1)'(RING_DEPTH) - {1'b0, lk_fill};
  assign fits = CW'(len_q) <= CW'(room);

  // Staging position of the next packet sample.
  assign do_store  = pkt_acc_q && (pkt_left_q != '0);
  assign pend_nx   = (pend_q == PW'(SPAN - 1)) ? '0 : pend_q + 1'b1;
  assign pend_slot = (pend_q >= PW'(RING_DEPTH)) ? SLW'(pend_q - PW'(RING_DEPTH))
                                                 : SLW'(pend_q);
  assign rd_slot   = (lk_rd_ptr >= PW'(RING_DEPTH)) ? SLW'(lk_rd_ptr - PW'(RING_DEPTH))
                                                    : SLW'(lk_rd_ptr);

  always_comb begin
    state_d    = state_q;
    pkt_acc_d  = pkt_acc_q;
    pkt_ring_d = pkt_ring_q;
    pkt_left_d = pkt_left_q;
    pend_d     = pend_q;
    spk_cnt_d  = spk_cnt_q;
    rd_vld_d   = 1'b0;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_kind_d = out_kind_q;
    out_smp_d  = out_smp_q;
    out_drop_d = out_drop_q;
    ptr_cmd    = '0;
    commit_ptr = pend_q;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = '0;
    acc_clr    = 1'b0;
    acc_add    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i[0] == OP_READ) begin
            acc_clr   = 1'b1;
            spk_cnt_d = '0;
            state_d   = ST_RISSUE;
          end else begin
            state_d = ST_WDEC;
          end
        end
      end

      ST_WDEC: begin
        // A first sample abandons any open packet and reports accept or drop.
        if (!first_q) begin
          state_d = ST_WSTORE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = KIND_STATUS;
          out_smp_d  = '0;
          out_drop_d = !(wr_ring_ok && fits);
          pkt_acc_d  = wr_ring_ok && fits;
          pkt_left_d = (wr_ring_ok && fits) ? len_q : '0;
          if (wr_ring_ok && fits) begin
            pkt_ring_d = wr_ring;
            pend_d     = lk_wr_ptr;
          end
          state_d = ST_WSTORE;
        end
      end

      ST_WSTORE: begin
        if (do_store) begin
          mem_en     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = AW'(pkt_ring_q) * AW'(RING_DEPTH) + AW'(pend_slot);
          pend_d     = pend_nx;
          pkt_left_d = pkt_left_q - 1'b1;
        end
        // The last sample makes the staged samples visible to reads.
        if (last_q && pkt_acc_q) begin
          ptr_cmd.commit = 1'b1;
          commit_ptr     = do_store ? pend_nx : pend_q;
          pkt_acc_d      = 1'b0;
          pkt_left_d     = '0;
        end
        state_d = ST_IDLE;
      end

      ST_RISSUE: begin
        acc_add = rd_vld_q;
        if (rd_ch_ok && (lk_fill != '0)) begin
          ptr_cmd.pop = 1'b1;
          mem_en      = 1'b1;
          mem_addr    = AW'(rd_ring) * AW'(RING_DEPTH) + AW'(rd_slot);
          rd_vld_d    = 1'b1;
        end
        if (int'(spk_cnt_q) == NUM_SPEAKERS - 1) begin
          state_d = ST_RDRAIN;
        end else begin
          spk_cnt_d = spk_cnt_q + 1'b1;
        end
      end

      ST_RDRAIN: begin
        acc_add = rd_vld_q;
        state_d = ST_ROUT;
      end

      ST_ROUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = KIND_MIX;
          out_smp_d  = mix_sum;
          out_drop_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pkt_acc_q  <= 1'b0;
      pkt_ring_q <= '0;
      pkt_left_q <= '0;
      pend_q     <= '0;
      spk_cnt_q  <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pkt_acc_q  <= pkt_acc_d;
      pkt_ring_q <= pkt_ring_d;
      pkt_left_q <= pkt_left_d;
      pend_q     <= pend_d;
      spk_cnt_q  <= spk_cnt_d;
      rd_vld_q   <= rd_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      first_q <= s_axis_tuser_i[1];
      last_q  <= s_axis_tlast_i;
      spk_q   <= s_axis_tdata_i[1:0];
      ch_q    <= s_axis_tdata_i[3:2];
      smp_q   <= s_axis_tdata_i[19:4];
      len_q   <= s_axis_tdata_i[32:20];
    end
    out_kind_q <= out_kind_d;
    out_smp_q  <= out_smp_d;
    out_drop_q <= out_drop_d;
  end

  mrsm_ptr_tbl #(
    .RING_DEPTH (RING_DEPTH),
    .NUM_RINGS  (NUM_RINGS),
    .RIDX_W     (RIDX_W),
    .PW         (PW)
  ) u_ptr_tbl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ptr_cmd),
    .idx_i        (lk_idx),
    .commit_idx_i (pkt_ring_q),
    .commit_ptr_i (commit_ptr),
    .rd_ptr_o     (lk_rd_ptr),
    .wr_ptr_o     (lk_wr_ptr),
    .fill_o       (lk_fill)
  );

  mrsm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (smp_q),
    .rdata_o (mem_rdata)
  );

  mrsm_mix_acc #(
    .NUM_SPEAKERS (NUM_SPEAKERS)
  ) u_mix_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (acc_clr),
    .add_i    (acc_add),
    .sample_i (mem_rdata),
    .sum_o    (mix_sum)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - SAMPLE_W - 1){1'b0}}, out_drop_q, out_smp_q};
  assign m_axis_tuser_o  = out_kind_q;

endmodule

/* sim/tb_multi_ring_saturating_mixer_core.sv */
// Self-checking testbench of multi_ring_saturating_mixer_core: directed, capacity and random
// packet traffic checked against a behavioral model of the per-ring FIFOs and the mixer.
// Depends on mrsm_pkg and the design files of the block.
module tb_multi_ring_saturating_mixer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mrsm_pkg::*;

  localparam int RING_DEPTH   = DEF_RING_DEPTH;
  localparam int NUM_SPEAKERS = DEF_NUM_SPEAKERS;
  localparam int NUM_CHANNELS = DEF_NUM_CHANNELS;
  localparam int NUM_RINGS    = NUM_SPEAKERS * NUM_CHANNELS;
  // Ring pointers count modulo twice the depth, so one extra bit tells full from empty.
  localparam int PTR_W        = $clog2(2 * RING_DEPTH);
  // A read word is the slowest one, with one memory read per speaker; SETTLE_CYCLES, the
  // quiet time before a phase change and at the end, is scaled from its length.
  localparam int SETTLE_CYCLES = 4 * (NUM_SPEAKERS + 3);
  localparam int RANDOM_WORDS  = 1200;
  localparam int CALM_WORDS    = 200;

  // One input word, field by field.
  typedef struct {
    logic                       op;
    logic [1:0]                 speaker;
    logic [1:0]                 channel;
    logic signed [SAMPLE_W-1:0] pcm;
    logic                       first;
    logic                       last;
    logic [LEN_W-1:0]           len;
  } mixer_word_t;

  // One output word, field by field.
  typedef struct {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] mixed;
    logic                       dropped;
  } mixer_result_t;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [S_TUSER_W-1:0] s_tuser  = '0;
  logic                 s_tlast  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // Random idling of the sender and of the receiver; both are switched off near the end.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  int errors         = 0;
  int words_sent     = 0;
  int reads_issued   = 0;
  int status_issued  = 0;
  int drops_foreseen = 0;

  // Mixed samples and packet statuses still owed by the block, oldest first.
  mixer_result_t awaited_outputs[$];

  // Behavioral copy of the ring storage and the open-packet state. The storage starts
  // undefined, which is harmless because only committed entries are ever read.
  logic signed [SAMPLE_W-1:0] ring_mem [NUM_RINGS*RING_DEPTH];
  logic [PTR_W-1:0]           head_ptr [NUM_RINGS];
  logic [PTR_W-1:0]           tail_ptr [NUM_RINGS];
  logic [PTR_W-1:0]           stage_ptr;
  bit                         open_ok;
  int                         open_ring;
  int                         open_left;

  always #5 clk_i = ~clk_i;

  multi_ring_saturating_mixer_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Number of committed samples waiting in a ring.
  function automatic int ring_level(input int r);
    logic [PTR_W-1:0] d;
    d = tail_ptr[r] - head_ptr[r];
    return int'(d);
  endfunction

  // True while any ring of the channel still holds a committed sample.
  function automatic bit channel_busy(input int ch);
    bit busy;
    busy = 1'b0;
    for (int s = 0; s < NUM_SPEAKERS; s++) begin
      if (ring_level(s * NUM_CHANNELS + ch) != 0) busy = 1'b1;
    end
    return busy;
  endfunction

  // Applies one accepted word to the model rings and queues the output word it causes.
  // A read pops every non-empty ring of its channel and gives the saturated sum; the first
  // word of a packet gives its admission status; other writes give nothing.
  task automatic apply_to_rings(input mixer_word_t w);
    int            r;
    int            acc;
    mixer_result_t res;
    if (w.op == OP_READ) begin
      acc = 0;
      // A read of a channel that does not exist pops nothing and mixes to silence.
      if (int'(w.channel) < NUM_CHANNELS) begin
        for (int s = 0; s < NUM_SPEAKERS; s++) begin
          r = s * NUM_CHANNELS + int'(w.channel);
          if (ring_level(r) != 0) begin
            acc += ring_mem[r * RING_DEPTH + int'(head_ptr[r]) % RING_DEPTH];
            head_ptr[r] = head_ptr[r] + 1'b1;
          end
        end
      end
      if (acc > SAT_MAX) acc = SAT_MAX;
      else if (acc < SAT_MIN) acc = SAT_MIN;
      res.kind    = KIND_MIX;
      res.mixed   = acc[SAMPLE_W-1:0];
      res.dropped = 1'b0;
      awaited_outputs.push_back(res);
      reads_issued++;
    end else begin
      if (w.first) begin
        // A new first word abandons whatever packet was still open.
        res.dropped = 1'b1;
        open_ok     = 1'b0;
        open_left   = 0;
        if (int'(w.speaker) < NUM_SPEAKERS && int'(w.channel) < NUM_CHANNELS) begin
          r = int'(w.speaker) * NUM_CHANNELS + int'(w.channel);
          if (int'(w.len) <= RING_DEPTH - ring_level(r)) begin
            res.dropped = 1'b0;
            open_ok     = 1'b1;
            open_ring   = r;
            open_left   = int'(w.len);
            stage_ptr   = tail_ptr[r];
          end
        end
        res.kind  = KIND_STATUS;
        res.mixed = '0;
        awaited_outputs.push_back(res);
        status_issued++;
        if (res.dropped) drops_foreseen++;
      end
      // Samples are staged past the tail; anything beyond the declared length is ignored.
      if (open_ok && open_left != 0) begin
        ring_mem[open_ring * RING_DEPTH + int'(stage_ptr) % RING_DEPTH] = w.pcm;
        stage_ptr = stage_ptr + 1'b1;
        open_left--;
      end
      // The last word makes the staged samples visible.
      if (w.last && open_ok) begin
        tail_ptr[open_ring] = stage_ptr;
        open_ok   = 1'b0;
        open_left = 0;
      end
    end
  endtask

  // A random sample that hits both full-scale values now and then.
  function automatic logic signed [SAMPLE_W-1:0] rand_pcm();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_W'(SAT_MAX);
      1:       return SAMPLE_W'(SAT_MIN);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic mixer_word_t write_word(input logic [1:0] spk, input logic [1:0] ch,
                                             input logic signed [SAMPLE_W-1:0] pcm,
                                             input logic first, input logic last,
                                             input logic [LEN_W-1:0] len);
    mixer_word_t w;
    w.op      = OP_WRITE;
    w.speaker = spk;
    w.channel = ch;
    w.pcm     = pcm;
    w.first   = first;
    w.last    = last;
    w.len     = len;
    return w;
  endfunction

  // A read request; every field but the op and the channel is random, since the block ignores them.
  function automatic mixer_word_t read_word(input logic [1:0] ch);
    mixer_word_t w;
    w.op      = OP_READ;
    w.speaker = 2'($urandom);
    w.channel = ch;
    w.pcm     = SAMPLE_W'($urandom);
    w.first   = 1'($urandom);
    w.last    = 1'($urandom);
    w.len     = LEN_W'($urandom);
    return w;
  endfunction

  // Offers one word on the input stream and returns in the time step of its handshake.
  // tvalid stays high on return so that back-to-back words need no second assignment.
  task automatic send_word(input mixer_word_t w);
    logic [S_TDATA_W-1:0] data;
    data = '0;
    data[1:0]   = w.speaker;
    data[3:2]   = w.channel;
    data[19:4]  = w.pcm;
    data[32:20] = w.len;
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= {w.first, w.op};
    s_tlast  <= w.last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    apply_to_rings(w);
    words_sent++;
  endtask

  // Sends a packet of n_data words. The first word carries the declared length, which may
  // differ from n_data; the last word is marked only when close is set. The speaker,
  // channel and length fields of later words are random because the block ignores them.
  task automatic send_packet(input logic [1:0] spk, input logic [1:0] ch,
                             input logic [LEN_W-1:0] len, input int n_data, input bit close);
    for (int i = 0; i < n_data; i++) begin
      if (i == 0) begin
        send_word(write_word(spk, ch, rand_pcm(), 1'b1, close && n_data == 1, len));
      end else begin
        send_word(write_word(2'($urandom), 2'($urandom), rand_pcm(), 1'b0,
                             close && i == n_data - 1, LEN_W'($urandom)));
      end
    end
  endtask

  // Stops offering words and waits until every owed output word has come back, then a
  // little longer in case the last word was still being worked on.
  task automatic settle_mixer();
    s_tvalid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Reads of empty channels, and of the channel index that does not exist, give silence.
  task automatic test_empty_reads();
    for (int ch = 0; ch < 4; ch++) send_word(read_word(2'(ch)));
  endtask

  // Sums clip at both full-scale limits, and an exhausted channel falls back to silence.
  task automatic test_mix_saturation();
    send_word(write_word(2'd0, 2'd0, SAMPLE_W'(SAT_MAX), 1'b1, 1'b0, LEN_W'(2)));
    send_word(write_word(2'd0, 2'd0, SAMPLE_W'(SAT_MAX), 1'b0, 1'b1, LEN_W'(0)));
    send_word(write_word(2'd1, 2'd0, SAMPLE_W'(1), 1'b1, 1'b1, LEN_W'(1)));
    repeat (3) send_word(read_word(2'd0));
    send_word(write_word(2'd2, 2'd1, SAMPLE_W'(SAT_MIN), 1'b1, 1'b1, LEN_W'(1)));
    send_word(write_word(2'd3, 2'd1, SAMPLE_W'(SAT_MIN), 1'b1, 1'b1, LEN_W'(1)));
    repeat (2) send_word(read_word(2'd1));
  endtask

  // Admission rules: zero length, oversize length, missing channel, surplus samples,
  // abandoned packets, stray last words and the exact free-space boundary.
  task automatic test_packet_admission();
    // A zero-length packet is accepted and its sample is thrown away.
    send_word(write_word(2'd0, 2'd2, rand_pcm(), 1'b1, 1'b1, LEN_W'(0)));
    // The largest length field never fits; the word after it belongs to no packet.
    send_word(write_word(2'd1, 2'd2, rand_pcm(), 1'b1, 1'b0, '1));
    send_word(write_word(2'd1, 2'd2, rand_pcm(), 1'b0, 1'b1, '1));
    // A channel that does not exist is reported as dropped.
    send_word(write_word(2'd2, 2'd3, rand_pcm(), 1'b1, 1'b1, LEN_W'(1)));
    // Only the declared single sample is kept; later words ignore their own ring fields.
    send_word(write_word(2'd2, 2'd2, rand_pcm(), 1'b1, 1'b0, LEN_W'(1)));
    send_word(write_word(2'd0, 2'd0, rand_pcm(), 1'b0, 1'b0, LEN_W'(9)));
    send_word(write_word(2'd1, 2'd1, rand_pcm(), 1'b0, 1'b1, LEN_W'(9)));
    // An open packet is abandoned by a new first word and its staged sample never shows.
    send_word(write_word(2'd3, 2'd2, rand_pcm(), 1'b1, 1'b0, LEN_W'(2)));
    send_word(write_word(2'd3, 2'd2, rand_pcm(), 1'b1, 1'b1, LEN_W'(1)));
    // A last word with no open packet does nothing.
    send_word(write_word(2'd3, 2'd2, rand_pcm(), 1'b0, 1'b1, LEN_W'(1)));
    // A read of the missing channel pops nothing; channel 2 then mixes both rings.
    send_word(read_word(2'd3));
    repeat (2) send_word(read_word(2'd2));
    // The free space bounds the length exactly: a full-depth claim fits an empty ring,
    // but once one sample is committed only one less fits.
    send_packet(2'd0, 2'd1, LEN_W'(RING_DEPTH), 1, 1'b1);
    send_packet(2'd0, 2'd1, LEN_W'(RING_DEPTH), 1, 1'b1);
    send_packet(2'd0, 2'd1, LEN_W'(RING_DEPTH - 1), 1, 1'b1);
    repeat (3) send_word(read_word(2'd1));
  endtask

  // Long packets in two rings of one channel, the exact free-space boundary on a partly
  // filled ring, and a drain that runs past the point where the channel goes silent.
  task automatic test_ring_capacity();
    while (channel_busy(2)) send_word(read_word(2'd2));
    send_packet(2'd3, 2'd2, LEN_W'(48), 48, 1'b1);
    send_packet(2'd1, 2'd2, LEN_W'(20), 20, 1'b1);
    // With 48 samples held, a claim one above the free space drops and an exact one fits.
    send_packet(2'd3, 2'd2, LEN_W'(RING_DEPTH - 47), 1, 1'b1);
    send_packet(2'd3, 2'd2, LEN_W'(RING_DEPTH - 48), 2, 1'b1);
    repeat (52) send_word(read_word(2'd2));
  endtask

  // Mostly well-formed packets and read bursts with random content, with some broken
  // packets, oversize claims and stray words mixed in. Idling comes and goes in stretches
  // and is off for the final words.
  task automatic test_random_traffic();
    int          stop_at;
    int          pick;
    int          len;
    logic [1:0]  spk;
    logic [1:0]  ch;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      if (words_sent >= stop_at - CALM_WORDS) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        tx_idle = 1'($urandom);
        rx_idle = 1'($urandom);
      end
      spk  = 2'($urandom_range(0, 3));
      ch   = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        send_packet(spk, ch, LEN_W'(len), len, 1'b1);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) send_word(read_word(ch));
      end else if (pick < 85) begin
        // Truncated, overlong or never closed.
        len = $urandom_range(1, 8);
        case ($urandom_range(0, 2))
          0:       send_packet(spk, ch, LEN_W'(len), $urandom_range(1, len), 1'b1);
          1:       send_packet(spk, ch, LEN_W'(len), len + $urandom_range(1, 3), 1'b1);
          default: send_packet(spk, ch, LEN_W'(len), $urandom_range(1, len), 1'b0);
        endcase
      end else if (pick < 92) begin
        send_packet(spk, ch, LEN_W'($urandom), $urandom_range(1, 3), 1'b1);
      end else if (pick < 96) begin
        send_packet(spk, ch, LEN_W'(0), $urandom_range(1, 3), 1'b1);
      end else begin
        send_word(write_word(spk, ch, rand_pcm(), 1'b0, 1'($urandom), LEN_W'($urandom)));
      end
    end
  endtask

  // Receiver side: ready drops for random bursts.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Every accepted output word is compared field by field with the oldest owed one.
  always @(posedge clk_i) begin : check_outputs
    mixer_result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (awaited_outputs.size() == 0) begin
        $display("%0t: output word with nothing owed: expected none, actual tdata %h tuser %h",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = awaited_outputs.pop_front();
        if (m_tuser[0] !== want.kind) begin
          $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind,
                   m_tuser[0]);
          errors++;
        end
        if (m_tdata[15:0] !== want.mixed) begin
          $display("%0t: mixed sample mismatch: expected %0d, actual %0d", $time,
                   want.mixed, $signed(m_tdata[15:0]));
          errors++;
        end
        if (m_tdata[16] !== want.dropped) begin
          $display("%0t: packet dropped mismatch: expected %0d, actual %0d", $time,
                   want.dropped, m_tdata[16]);
          errors++;
        end
      end
    end
  end

  // Reset is applied once; the test phases then run in turn, each one left to drain
  // completely before the next begins.
  initial begin
    for (int r = 0; r < NUM_RINGS; r++) begin
      head_ptr[r] = '0;
      tail_ptr[r] = '0;
    end
    stage_ptr = '0;
    open_ok   = 1'b0;
    open_ring = 0;
    open_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_empty_reads();
    settle_mixer();
    test_mix_saturation();
    settle_mixer();
    test_packet_admission();
    settle_mixer();
    test_ring_capacity();
    settle_mixer();
    test_random_traffic();
    settle_mixer();

    $display("Sent %0d words: %0d mixed reads and %0d packet statuses, %0d of them drops.",
             words_sent, reads_issued, status_issued, drops_foreseen);
    $display("Covered saturation, admission corner cases, ring space limits and random traffic.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Timeout with %0d output words still owed.", awaited_outputs.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
